FILE: rtl/fifo_page_replacement_pinned_macros.svh
// Assertion macros for the FIFO page-replacement store.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef FIFO_PAGE_REPLACEMENT_PINNED_MACROS_SVH
`define FIFO_PAGE_REPLACEMENT_PINNED_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define FPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define FPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FPR_ASSERT_NOW(lbl, ante, cons, msg)
`define FPR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/fpr_pkg.sv
// Shared types and constants for the FIFO page-replacement store.
// No dependencies.
package fpr_pkg;

	localparam int CAPACITY_DEF = 8;
	localparam int PAGE_W       = 64;
	localparam int ACT_W        = 3;
	localparam int SIDX_W       = 3;
	localparam int FIDX_W       = 3;

	// action codes; 5..7 are unused and fail
	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH   = 3'd0,
		ACT_POP    = 3'd1,
		ACT_FIND   = 3'd2,
		ACT_SETPIN = 3'd3,
		ACT_CLEAR  = 3'd4
	} action_t;

	// input word
	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [PAGE_W-1:0] page;
		logic [SIDX_W-1:0] start_index;
		logic              pin_value;
	} req_t;

	// result word
	typedef struct packed {
		logic              status;
		logic [PAGE_W-1:0] out_page;
		logic              evicted;
		logic [FIDX_W-1:0] found_index;
	} rsp_t;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_MOD,
		S_SEARCH,
		S_TAKE,
		S_GRAB,
		S_MOVE,
		S_PUSH,
		S_SCAN,
		S_CLEAR,
		S_FIN
	} state_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;
		logic mod_step;
		logic search_step;
		logic take;
		logic grab;
		logic move;
		logic push_wr;
		logic scan;
		logic clear;
		logic fin;
		logic ok;
	} ctl_t;

	// datapath -> controller status
	typedef struct packed {
		logic cnt_zero;
		logic cnt_full;
		logic pos_ge_cnt;
		logic pin_at_pos;
		logic search_last;
		logic more;
		logic scan_end;
		logic match;
		logic any;
	} st_t;

endpackage

FILE: rtl/fpr_ctrl.sv
// Sequencer for the FIFO page-replacement store.
// Depends on fpr_pkg; drives fpr_dp through ctl_t and reads st_t.
module fpr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [fpr_pkg::ACT_W-1:0] action,
	output logic                   busy,
	output logic                   done,
	output fpr_pkg::ctl_t          ctl,
	input  fpr_pkg::st_t           st
);
	import fpr_pkg::*;

	state_t           state_q, state_d;
	logic [ACT_W-1:0] act_q;
	logic             ok_q, ok_d;
	logic             done_q;

	// state and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q   <= ACT_PUSH;
			ok_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ok_q    <= ok_d;
			done_q  <= ctl.fin;
			if (ctl.load) begin
				act_q <= action;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		ok_d    = ok_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					case (action)
						ACT_PUSH: state_d = st.cnt_full ? S_MOD : S_PUSH;
						ACT_POP: begin
							if (st.cnt_zero) begin
								ok_d    = 1'b0;
								state_d = S_FIN;
							end else begin
								state_d = S_MOD;
							end
						end
						ACT_FIND:   state_d = S_SCAN;
						ACT_SETPIN: state_d = S_SCAN;
						ACT_CLEAR:  state_d = S_CLEAR;
						default: begin
							ok_d    = 1'b0;
							state_d = S_FIN;
						end
					endcase
				end
			end
			// reduce start position below the count
			S_MOD: begin
				if (st.pos_ge_cnt) begin
					ctl.mod_step = 1'b1;
				end else begin
					state_d = S_SEARCH;
				end
			end
			// circular walk for an unpinned entry
			S_SEARCH: begin
				if (!st.pin_at_pos) begin
					state_d = S_TAKE;
				end else if (st.search_last) begin
					ok_d    = 1'b0;
					state_d = S_FIN;
				end else begin
					ctl.search_step = 1'b1;
				end
			end
			S_TAKE: begin
				ctl.take = 1'b1;
				state_d  = S_GRAB;
			end
			S_GRAB: begin
				ctl.grab = 1'b1;
				if (st.more) begin
					state_d = S_MOVE;
				end else if (act_q == ACT_PUSH) begin
					state_d = S_PUSH;
				end else begin
					ok_d    = 1'b1;
					state_d = S_FIN;
				end
			end
			// shift later entries down one per cycle
			S_MOVE: begin
				ctl.move = 1'b1;
				if (!st.more) begin
					if (act_q == ACT_PUSH) begin
						state_d = S_PUSH;
					end else begin
						ok_d    = 1'b1;
						state_d = S_FIN;
					end
				end
			end
			S_PUSH: begin
				ctl.push_wr = 1'b1;
				ok_d        = 1'b1;
				state_d     = S_FIN;
			end
			// compare stored pages one per cycle
			S_SCAN: begin
				ctl.scan = 1'b1;
				if (st.match && act_q == ACT_FIND) begin
					ok_d    = 1'b1;
					state_d = S_FIN;
				end else if (st.scan_end) begin
					ok_d    = (act_q == ACT_SETPIN) && st.any;
					state_d = S_FIN;
				end
			end
			S_CLEAR: begin
				ctl.clear = 1'b1;
				ok_d      = 1'b1;
				state_d   = S_FIN;
			end
			S_FIN: begin
				ctl.fin = 1'b1;
				ctl.ok  = ok_q;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

FILE: rtl/fpr_dp.sv
// Datapath for the FIFO page-replacement store: entry RAM, pinned marks,
// count and walk pointers. Depends on fpr_pkg; commanded by fpr_ctrl.
module fpr_dp #(
	parameter int CAPACITY = fpr_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  fpr_pkg::req_t req,
	input  fpr_pkg::ctl_t ctl,
	output fpr_pkg::st_t  st,
	output fpr_pkg::rsp_t rsp
);
	import fpr_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > SIDX_W) ? CW : SIDX_W;

	// entry RAM
	logic [PAGE_W-1:0] mem [CAPACITY];

	req_t              req_q;
	logic [CW-1:0]     count_q;
	logic [CAPACITY-1:0] pins_q, pins_shift, pins_dn;
	logic [PW-1:0]     pos_q;
	logic [CW-1:0]     k_q, k_inc;
	logic [CW-1:0]     ptr_q;
	logic [CW:0]       ptr_inc, ptr_inc2;
	logic              any_q;
	logic              rd_vld_s1;
	logic [PAGE_W-1:0] rd_data_s1;
	logic [IW-1:0]     rd_idx_s1;
	logic [PAGE_W-1:0] opage_q;
	logic              ev_q;
	logic [FIDX_W-1:0] found_q;
	rsp_t              rsp_q;

	logic [PW-1:0]     cnt_ext;
	logic              ptr_lt, more, match;
	logic              rd_en, wr_en;
	logic [IW-1:0]     rd_addr, wr_addr;
	logic [PAGE_W-1:0] wr_data;

	// status toward the controller
	always_comb begin
		cnt_ext  = PW'(count_q);
		k_inc    = k_q + CW'(1);
		ptr_inc  = {1'b0, ptr_q} + (CW+1)'(1);
		ptr_inc2 = {1'b0, ptr_q} + (CW+1)'(2);
		ptr_lt   = (ptr_q < count_q);
		more     = (ptr_inc < {1'b0, count_q});
		match    = rd_vld_s1 && (rd_data_s1 == req_q.page);

		st.cnt_zero    = (count_q == '0);
		st.cnt_full    = (count_q == CW'(CAPACITY));
		st.pos_ge_cnt  = (pos_q >= cnt_ext);
		st.pin_at_pos  = pins_q[pos_q[IW-1:0]];
		st.search_last = (k_inc >= count_q);
		st.more        = more;
		st.scan_end    = !ptr_lt && !rd_vld_s1;
		st.match       = match;
		st.any         = any_q;
	end

	// RAM port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_data_s1;
		if (ctl.take) begin
			rd_en   = 1'b1;
			rd_addr = pos_q[IW-1:0];
		end else if (ctl.grab) begin
			rd_en   = more;
			rd_addr = ptr_inc[IW-1:0];
		end else if (ctl.move) begin
			rd_en   = more;
			rd_addr = ptr_inc2[IW-1:0];
			wr_en   = 1'b1;
			wr_addr = ptr_q[IW-1:0];
		end else if (ctl.scan) begin
			rd_en   = ptr_lt;
			rd_addr = ptr_q[IW-1:0];
		end
		if (ctl.push_wr) begin
			wr_en   = 1'b1;
			wr_addr = count_q[IW-1:0];
			wr_data = req_q.page;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
		if (ctl.scan) begin
			rd_idx_s1 <= ptr_q[IW-1:0];
		end
	end

	// marks with the removed position squeezed out
	always_comb begin
		pins_dn = pins_q >> 1;
		for (int i = 0; i < CAPACITY; i++) begin
			if (PW'(i) < pos_q) begin
				pins_shift[i] = pins_q[i];
			end else begin
				pins_shift[i] = pins_dn[i];
			end
		end
	end

	// control state: count, marks, read valid, match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			pins_q    <= '0;
			rd_vld_s1 <= 1'b0;
			any_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= ctl.scan && ptr_lt;
			if (ctl.load) begin
				any_q <= 1'b0;
			end else if (ctl.scan && match) begin
				any_q <= 1'b1;
			end
			if (ctl.clear) begin
				count_q <= '0;
				pins_q  <= '0;
			end else if (ctl.grab) begin
				count_q <= count_q - CW'(1);
				pins_q  <= pins_shift;
			end else if (ctl.push_wr) begin
				count_q                   <= count_q + CW'(1);
				pins_q[count_q[IW-1:0]]   <= req_q.pin_value;
			end else if (ctl.scan && match && req_q.action == ACT_SETPIN) begin
				pins_q[rd_idx_s1] <= req_q.pin_value;
			end
		end
	end

	// walk pointers and result fields
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q   <= req;
			pos_q   <= (req.action == ACT_PUSH) ? '0 : PW'(req.start_index);
			k_q     <= '0;
			ptr_q   <= '0;
			opage_q <= '0;
			ev_q    <= 1'b0;
			found_q <= '0;
		end else begin
			if (ctl.mod_step) begin
				pos_q <= pos_q - cnt_ext;
			end
			if (ctl.search_step) begin
				pos_q <= (pos_q + PW'(1) == cnt_ext) ? '0 : pos_q + PW'(1);
				k_q   <= k_inc;
			end
			if (ctl.take) begin
				ptr_q <= CW'(pos_q);
			end
			if (ctl.move || (ctl.scan && ptr_lt)) begin
				ptr_q <= ptr_inc[CW-1:0];
			end
			if (ctl.grab) begin
				opage_q <= rd_data_s1;
				ev_q    <= (req_q.action == ACT_PUSH);
			end
			if (ctl.scan && match && req_q.action == ACT_FIND) begin
				found_q <= FIDX_W'(rd_idx_s1);
			end
		end
		if (ctl.fin) begin
			rsp_q.status      <= !ctl.ok;
			rsp_q.out_page    <= opage_q;
			rsp_q.evicted     <= ev_q;
			rsp_q.found_index <= found_q;
		end
	end

	assign rsp = rsp_q;

endmodule

FILE: rtl/fifo_page_replacement_pinned.sv
// Top level of the FIFO page-replacement store with pinned entries; needs fpr_pkg,
// fpr_ctrl, fpr_dp and the assertion macro header.
// Sequencing: push without eviction writes the page and finishes; pop of an empty store
// and unknown actions go straight to the finish state with failure; find and set-pin scan
// the stored pages; pop and evicting push go through start reduction, pin search and one-entry shifts.
// One word at a time, next one taken in the done cycle; receiver cannot stall. Reset empties.
`include "fifo_page_replacement_pinned_macros.svh"
module fifo_page_replacement_pinned #(
	parameter int CAPACITY = fpr_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  fpr_pkg::req_t cmd,
	output logic          done,
	output fpr_pkg::rsp_t result
);
	import fpr_pkg::*;

	ctl_t ctl;
	st_t  st;

	// sequencer
	fpr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (cmd.action),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl),
		.st     (st)
	);

	// storage and walk logic
	fpr_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cmd),
		.ctl    (ctl),
		.st     (st),
		.rsp    (result)
	);

	// checks
	`FPR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not start work")
	`FPR_ASSERT_NOW(a_done_idle, done, !busy, "result strobed while still busy")
	`FPR_ASSERT_NOW(a_evict_ok, done && result.evicted, !result.status && result.found_index == '0, "eviction reported with bad status")

endmodule
